/* design/ctbm_pkg.sv */
// shared constants, types and address helpers for the clipped tile block type map
// no dependencies; compile first
`timescale 1ns / 1ps
`default_nettype none

package ctbm_pkg;

   // block and screen geometry
   localparam int MAX_BLOCK_ROWS = 4;
   localparam int MAX_BLOCK_COLS = 4;
   localparam int SCREEN_COLS    = 32;
   localparam int SCREEN_ROWS    = 24;
   localparam int TYPE_BITS      = 2;

   // packed map layout
   localparam int CELLS_PER_BYTE = 8 / TYPE_BITS;
   localparam int MAP_BYTES      = (SCREEN_ROWS * SCREEN_COLS + CELLS_PER_BYTE - 1)
                                   / CELLS_PER_BYTE;
   localparam int ADDR_W         = $clog2(MAP_BYTES);
   localparam int SLOT_W         = $clog2(CELLS_PER_BYTE);
   localparam int LIN_W          = $clog2(SCREEN_ROWS * SCREEN_COLS);
   localparam logic [7:0] TYPE_MASK = 8'((1 << TYPE_BITS) - 1);

   // walk counters
   localparam int BLOCK_CELLS = MAX_BLOCK_ROWS * MAX_BLOCK_COLS;
   localparam int DR_W        = (MAX_BLOCK_ROWS > 1) ? $clog2(MAX_BLOCK_ROWS) : 1;
   localparam int DC_W        = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
   localparam int BR_W        = $clog2(MAX_BLOCK_ROWS + 1);
   localparam int BC_W        = $clog2(MAX_BLOCK_COLS + 1);
   localparam int POS_W       = (BLOCK_CELLS > 1) ? $clog2(BLOCK_CELLS) : 1;

   // coordinate arithmetic width (anchor plus block offset, and screen bounds)
   localparam int COORD_W = 7;

   // channel field widths
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_DRAW   = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLIP_TOP    = 2'd0,
      CSR_CLIP_LEFT   = 2'd1,
      CSR_CLIP_HEIGHT = 2'd2,
      CSR_CLIP_WIDTH  = 2'd3
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } front_state_type;

   // one cell operation handed from front to back
   typedef struct packed {
      cmd_type                op;
      logic [ADDR_W-1:0]      addr;
      logic [SLOT_W-1:0]      slot;
      logic                   hit;
      logic [TYPE_BITS-1:0]   cell_type;
      logic [4:0]             row;
      logic [4:0]             col;
      logic [3:0]             index;
      logic                   last;
   } cell_op_type;

   // linear cell number in row-major order
   function automatic logic [LIN_W-1:0] map_lin(input logic [COORD_W-1:0] r,
                                                input logic [COORD_W-1:0] c);
      return LIN_W'(r) * LIN_W'(SCREEN_COLS) + LIN_W'(c);
   endfunction

   function automatic logic [ADDR_W-1:0] map_addr(input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c);
      return ADDR_W'(map_lin(r, c) >> SLOT_W);
   endfunction

   function automatic logic [SLOT_W-1:0] map_slot(input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c);
      return SLOT_W'(map_lin(r, c));
   endfunction

   // v inside [lo, lo + len) with no wrap
   function automatic logic in_span(input logic [COORD_W-1:0] v,
                                    input logic [COORD_W-1:0] lo,
                                    input logic [COORD_W-1:0] len);
      return (v >= lo) && ((v - lo) < len);
   endfunction

endpackage

`default_nettype wire

/* design/ctbm_intf.sv */
// valid/ready channel interfaces: command requests, cell responses, register writes
// depends on ctbm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ctbm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [4:0] anchor_row;
   logic [4:0] anchor_col;
   logic [2:0] block_rows;
   logic [2:0] block_cols;
   logic [1:0] cell_type;

   modport source (output valid, command, anchor_row, anchor_col, block_rows, block_cols,
                   cell_type, input ready);
   modport sink   (input valid, command, anchor_row, anchor_col, block_rows, block_cols,
                   cell_type, output ready);
endinterface

interface ctbm_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] cell_row;
   logic [4:0] cell_col;
   logic [3:0] cell_index;
   logic       blank;
   logic [1:0] read_type;
   logic       last;

   modport source (output valid, cell_row, cell_col, cell_index, blank, read_type, last,
                   input ready);
   modport sink   (input valid, cell_row, cell_col, cell_index, blank, read_type, last,
                   output ready);
endinterface

interface ctbm_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ctbm_pkg::CSR_IDX_W-1:0]   index;
   logic [ctbm_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/clipped_tile_block_type_map.sv */
// top level of the clipped tile block type map
// depends on ctbm_pkg, ctbm_intf, ctbm_front, ctbm_fifo and ctbm_back
//
//   channel   modport   carries                                        accepted when
//   req_bus   sink      command, anchor, block size, cell type         valid && ready
//   rsp_bus   source    cell row/col/index, blank, read type, last     valid && ready
//   csr_bus   sink      clip register index and data                   valid (ready held high)
//
// a draw or remove is accepted, then walks the block row-major up to its
// last kept cell, pushing only kept cells; nothing is walked when no cell is kept
// clear and query are pushed from idle without a walk, a clear also holds the back
// the back does one packed-byte read-modify-write per cell per cycle while the
// response register is free; a cell is read, merged in execute, then registered
// reset clears the whole map at once through per-byte valid flags, no sweep needed
// a stalled response backs up the back, then the queue, then req ready
`timescale 1ns / 1ps
`default_nettype none

module clipped_tile_block_type_map (
   input  wire logic   clock,
   input  wire logic   reset,
   ctbm_req_if.sink    req_bus,
   ctbm_rsp_if.source  rsp_bus,
   ctbm_csr_if.sink    csr_bus
);

   logic                    push, q_not_full, pop, q_not_empty;
   ctbm_pkg::cell_op_type   push_data, pop_data;

   // accept and walk
   ctbm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .csr       (csr_bus),
      .q_ready   (q_not_full),
      .push      (push),
      .push_data (push_data)
   );

   // decoupling queue
   ctbm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .not_full  (q_not_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (q_not_empty)
   );

   // map update and responses
   ctbm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (pop_data),
      .pop         (pop),
      .rsp         (rsp_bus)
   );

endmodule

`default_nettype wire

/* design/ctbm_front.sv */
// front end: clip registers, command accept, clip classification and block walk
// depends on ctbm_pkg and ctbm_intf; feeds cell operations into ctbm_fifo
`timescale 1ns / 1ps
`default_nettype none

module ctbm_front (
   input  wire logic               clock,
   input  wire logic               reset,
   ctbm_req_if.sink                req,
   ctbm_csr_if.sink                csr,
   input  wire logic               q_ready,
   output logic                    push,
   output ctbm_pkg::cell_op_type   push_data
);

   // clip box registers
   logic [4:0] clip_top_ff, clip_left_ff, clip_height_ff;
   logic [5:0] clip_width_ff;

   // walk state
   ctbm_pkg::front_state_type state_ff, state_in;
   ctbm_pkg::cmd_type         op_ff;
   logic [4:0]                ar_ff, ac_ff;
   logic [ctbm_pkg::BC_W-1:0] bc_ff;
   logic [ctbm_pkg::TYPE_BITS-1:0]    ty_ff;
   logic [ctbm_pkg::BLOCK_CELLS-1:0]  rem_ff, rem_in;
   logic [ctbm_pkg::DR_W-1:0]         dr_ff;
   logic [ctbm_pkg::DC_W-1:0]         dc_ff;
   logic [ctbm_pkg::POS_W-1:0]        pos_ff, base_ff;
   logic [ctbm_pkg::POS_W-1:0]        idx_ff;

   ctbm_pkg::cmd_type                 req_cmd;
   logic                              accept;
   logic                              is_block;
   logic [ctbm_pkg::BR_W-1:0]         br_eff;
   logic [ctbm_pkg::BC_W-1:0]         bc_eff;
   logic [ctbm_pkg::MAX_BLOCK_ROWS-1:0] row_ok;
   logic [ctbm_pkg::MAX_BLOCK_COLS-1:0] col_ok;
   logic [ctbm_pkg::BLOCK_CELLS-1:0]  keep_mask;
   logic [ctbm_pkg::BLOCK_CELLS-1:0]  pos_bit;
   logic                              cur_kept;
   logic                              step;
   logic                              row_end;
   logic [ctbm_pkg::COORD_W-1:0]      walk_r, walk_c, q_r, q_c;
   logic                              q_hit;

   assign csr.ready = 1'b1;
   assign req_cmd   = ctbm_pkg::cmd_type'(req.command);
   assign accept    = req.valid && req.ready;
   assign is_block  = (req_cmd == ctbm_pkg::CMD_DRAW) || (req_cmd == ctbm_pkg::CMD_REMOVE);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_top_ff    <= '0;
         clip_left_ff   <= '0;
         clip_height_ff <= 5'(ctbm_pkg::SCREEN_ROWS);
         clip_width_ff  <= 6'(ctbm_pkg::SCREEN_COLS);
      end else if (csr.valid) begin
         case (ctbm_pkg::csr_index_type'(csr.index))
            ctbm_pkg::CSR_CLIP_TOP:    clip_top_ff    <= csr.data[4:0];
            ctbm_pkg::CSR_CLIP_LEFT:   clip_left_ff   <= csr.data[4:0];
            ctbm_pkg::CSR_CLIP_HEIGHT: clip_height_ff <= csr.data[4:0];
            ctbm_pkg::CSR_CLIP_WIDTH:  clip_width_ff  <= csr.data;
            default: ;
         endcase
      end
   end

   // saturate block size
   always_comb begin
      if (4'(req.block_rows) > 4'(ctbm_pkg::MAX_BLOCK_ROWS)) begin
         br_eff = ctbm_pkg::BR_W'(ctbm_pkg::MAX_BLOCK_ROWS);
      end else begin
         br_eff = ctbm_pkg::BR_W'(req.block_rows);
      end
      if (4'(req.block_cols) > 4'(ctbm_pkg::MAX_BLOCK_COLS)) begin
         bc_eff = ctbm_pkg::BC_W'(ctbm_pkg::MAX_BLOCK_COLS);
      end else begin
         bc_eff = ctbm_pkg::BC_W'(req.block_cols);
      end
   end

   // classify rows and columns of the block: in block, on screen, inside clip box (removes are not clipped)
   always_comb begin
      logic [ctbm_pkg::COORD_W-1:0] rv;
      logic [ctbm_pkg::COORD_W-1:0] cv;
      rv = '0;
      cv = '0;
      for (int i = 0; i < ctbm_pkg::MAX_BLOCK_ROWS; i++) begin
         rv = ctbm_pkg::COORD_W'(req.anchor_row) + ctbm_pkg::COORD_W'(i);
         row_ok[i] = (ctbm_pkg::BR_W'(i) < br_eff)
                  && (rv < ctbm_pkg::COORD_W'(ctbm_pkg::SCREEN_ROWS))
                  && ((req_cmd == ctbm_pkg::CMD_REMOVE)
                      || ctbm_pkg::in_span(rv, ctbm_pkg::COORD_W'(clip_top_ff),
                                           ctbm_pkg::COORD_W'(clip_height_ff)));
      end
      for (int j = 0; j < ctbm_pkg::MAX_BLOCK_COLS; j++) begin
         cv = ctbm_pkg::COORD_W'(req.anchor_col) + ctbm_pkg::COORD_W'(j);
         col_ok[j] = (ctbm_pkg::BC_W'(j) < bc_eff)
                  && (cv < ctbm_pkg::COORD_W'(ctbm_pkg::SCREEN_COLS))
                  && ((req_cmd == ctbm_pkg::CMD_REMOVE)
                      || ctbm_pkg::in_span(cv, ctbm_pkg::COORD_W'(clip_left_ff),
                                           ctbm_pkg::COORD_W'(clip_width_ff)));
      end
      for (int i = 0; i < ctbm_pkg::MAX_BLOCK_ROWS; i++) begin
         for (int j = 0; j < ctbm_pkg::MAX_BLOCK_COLS; j++) begin
            keep_mask[i * ctbm_pkg::MAX_BLOCK_COLS + j] = row_ok[i] && col_ok[j];
         end
      end
   end

   // current walk position
   assign pos_bit  = ctbm_pkg::BLOCK_CELLS'(1) << pos_ff;
   assign cur_kept = rem_ff[pos_ff];
   assign row_end  = (ctbm_pkg::BC_W'(dc_ff) == (bc_ff - ctbm_pkg::BC_W'(1)));
   assign walk_r   = ctbm_pkg::COORD_W'(ar_ff) + ctbm_pkg::COORD_W'(dr_ff);
   assign walk_c   = ctbm_pkg::COORD_W'(ac_ff) + ctbm_pkg::COORD_W'(dc_ff);
   assign q_r      = ctbm_pkg::COORD_W'(req.anchor_row);
   assign q_c      = ctbm_pkg::COORD_W'(req.anchor_col);
   assign q_hit    = (q_r < ctbm_pkg::COORD_W'(ctbm_pkg::SCREEN_ROWS))
                  && (q_c < ctbm_pkg::COORD_W'(ctbm_pkg::SCREEN_COLS));
   assign rem_in   = rem_ff & ~pos_bit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ctbm_pkg::ST_IDLE: begin
            if (accept && is_block && (keep_mask != '0)) begin
               state_in = ctbm_pkg::ST_WALK;
            end
         end
         ctbm_pkg::ST_WALK: begin
            if (step && (rem_in == '0)) begin
               state_in = ctbm_pkg::ST_IDLE;
            end
         end
         default: state_in = ctbm_pkg::ST_IDLE;
      endcase
   end

   // outputs: handshake and queue push
   always_comb begin
      req.ready = 1'b0;
      push      = 1'b0;
      step      = 1'b0;
      push_data = '0;
      case (state_ff)
         ctbm_pkg::ST_IDLE: begin
            req.ready         = q_ready;
            push              = accept && !is_block;
            push_data.op      = req_cmd;
            push_data.hit     = q_hit;
            push_data.addr    = q_hit ? ctbm_pkg::map_addr(q_r, q_c) : '0;
            push_data.slot    = q_hit ? ctbm_pkg::map_slot(q_r, q_c) : '0;
            push_data.row     = req.anchor_row;
            push_data.col     = req.anchor_col;
            push_data.last    = 1'b1;
         end
         ctbm_pkg::ST_WALK: begin
            step                = !cur_kept || q_ready;
            push                = cur_kept && q_ready;
            push_data.op        = op_ff;
            push_data.hit       = 1'b1;
            push_data.addr      = ctbm_pkg::map_addr(walk_r, walk_c);
            push_data.slot      = ctbm_pkg::map_slot(walk_r, walk_c);
            push_data.cell_type = ty_ff;
            push_data.row       = 5'(walk_r);
            push_data.col       = 5'(walk_c);
            push_data.index     = 4'(idx_ff);
            push_data.last      = (rem_in == '0);
         end
         default: ;
      endcase
   end

   // walk registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctbm_pkg::ST_IDLE;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ctbm_pkg::ST_IDLE) begin
            if (accept && is_block) begin
               rem_ff <= keep_mask;
            end
         end else if (step) begin
            rem_ff <= rem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ctbm_pkg::ST_IDLE) && accept) begin
         op_ff   <= req_cmd;
         ar_ff   <= req.anchor_row;
         ac_ff   <= req.anchor_col;
         bc_ff   <= bc_eff;
         ty_ff   <= (req_cmd == ctbm_pkg::CMD_DRAW)
                    ? ctbm_pkg::TYPE_BITS'(req.cell_type) : '0;
         dr_ff   <= '0;
         dc_ff   <= '0;
         pos_ff  <= '0;
         base_ff <= '0;
         idx_ff  <= '0;
      end else if (step) begin
         idx_ff <= idx_ff + ctbm_pkg::POS_W'(1);
         if (row_end) begin
            dc_ff   <= '0;
            dr_ff   <= dr_ff + ctbm_pkg::DR_W'(1);
            base_ff <= base_ff + ctbm_pkg::POS_W'(ctbm_pkg::MAX_BLOCK_COLS);
            pos_ff  <= base_ff + ctbm_pkg::POS_W'(ctbm_pkg::MAX_BLOCK_COLS);
         end else begin
            dc_ff  <= dc_ff + ctbm_pkg::DC_W'(1);
            pos_ff <= pos_ff + ctbm_pkg::POS_W'(1);
         end
      end
   end

   // no walk left over while idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ctbm_pkg::ST_IDLE) |-> (rem_ff == '0))
      else $error("front idle with cells left to walk");

   // a query is always a single final transaction
   assert property (@(posedge clock) disable iff (reset)
      (push && (push_data.op == ctbm_pkg::CMD_QUERY)) |-> push_data.last)
      else $error("query pushed without last");

   // never push into a full queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> q_ready)
      else $error("push into full queue");

endmodule

`default_nettype wire

/* design/ctbm_fifo.sv */
// small queue of cell operations between front and back
// depends on ctbm_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctbm_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire ctbm_pkg::cell_op_type push_data,
   output logic                    not_full,
   input  wire logic               pop,
   output ctbm_pkg::cell_op_type   pop_data,
   output logic                    not_empty
);

   ctbm_pkg::cell_op_type             entries_ff [ctbm_pkg::QUEUE_DEPTH];
   logic [ctbm_pkg::QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [ctbm_pkg::QCNT_W-1:0]       count_ff;

   assign not_full  = (count_ff != ctbm_pkg::QCNT_W'(ctbm_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == ctbm_pkg::QPTR_W'(ctbm_pkg::QUEUE_DEPTH - 1))
                         ? '0 : wr_ptr_ff + ctbm_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == ctbm_pkg::QPTR_W'(ctbm_pkg::QUEUE_DEPTH - 1))
                         ? '0 : rd_ptr_ff + ctbm_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + ctbm_pkg::QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - ctbm_pkg::QCNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

/* design/ctbm_back.sv */
// back end: packed type map memory, read-modify-write pipe and response register
// depends on ctbm_pkg and ctbm_intf; drains ctbm_fifo
`timescale 1ns / 1ps
`default_nettype none

module ctbm_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_not_empty,
   input  wire ctbm_pkg::cell_op_type q_data,
   output logic                    pop,
   ctbm_rsp_if.source              rsp
);

   // map storage; a byte never written since reset or clear reads as zero
   logic [7:0]                        mem_ff [ctbm_pkg::MAP_BYTES];
   logic [ctbm_pkg::MAP_BYTES-1:0]    vld_ff;

   // execute stage
   ctbm_pkg::cell_op_type             b_ff;
   logic                              b_vld_ff;
   logic [7:0]                        rdata_ff;
   logic                              rhit_ff;

   // last written byte, covers a read issued in the cycle of that write
   logic                              fwd_vld_ff;
   logic [ctbm_pkg::ADDR_W-1:0]       fwd_addr_ff;
   logic [7:0]                        fwd_byte_ff;

   // response register
   logic                              rsp_vld_ff;
   logic [4:0]                        row_ff, col_ff;
   logic [3:0]                        index_ff;
   logic                              blank_ff, last_ff;
   logic [1:0]                        read_type_ff;

   logic                              out_free, b_adv, b_clear, emit, wr_en;
   logic [2:0]                        sh;
   logic [7:0]                        base_byte, merged;
   logic [ctbm_pkg::TYPE_BITS-1:0]    stored_type;

   // pipe control
   assign out_free = !rsp_vld_ff || rsp.ready;
   assign b_clear  = (b_ff.op == ctbm_pkg::CMD_CLEAR);
   assign b_adv    = b_vld_ff && (b_clear || out_free);
   assign pop      = q_not_empty && (!b_vld_ff || (b_adv && !b_clear));
   assign emit     = b_adv && !b_clear;
   assign wr_en    = b_adv && ((b_ff.op == ctbm_pkg::CMD_DRAW)
                               || (b_ff.op == ctbm_pkg::CMD_REMOVE));

   // byte merge
   always_comb begin
      sh = 3'(b_ff.slot) * 3'(ctbm_pkg::TYPE_BITS);
      if (fwd_vld_ff && (fwd_addr_ff == b_ff.addr)) begin
         base_byte = fwd_byte_ff;
      end else begin
         base_byte = rhit_ff ? rdata_ff : 8'h00;
      end
      stored_type = ctbm_pkg::TYPE_BITS'(base_byte >> sh);
      merged = (base_byte & ~(ctbm_pkg::TYPE_MASK << sh)) | (8'(b_ff.cell_type) << sh);
   end

   // memory read, registered
   always_ff @(posedge clock) begin
      if (pop) begin
         rdata_ff <= mem_ff[q_data.addr];
      end
   end

   // memory write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[b_ff.addr] <= merged;
      end
   end

   // valid bits, execute stage and forward register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         b_vld_ff   <= 1'b0;
         fwd_vld_ff <= 1'b0;
      end else begin
         if (b_adv && b_clear) begin
            vld_ff     <= '0;
            fwd_vld_ff <= 1'b0;
         end else if (wr_en) begin
            vld_ff[b_ff.addr] <= 1'b1;
            fwd_vld_ff        <= 1'b1;
         end
         if (pop) begin
            b_vld_ff <= 1'b1;
         end else if (b_adv) begin
            b_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_ff    <= q_data;
         rhit_ff <= vld_ff[q_data.addr];
      end
      if (wr_en) begin
         fwd_addr_ff <= b_ff.addr;
         fwd_byte_ff <= merged;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (emit) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         row_ff       <= b_ff.row;
         col_ff       <= b_ff.col;
         index_ff     <= b_ff.index;
         blank_ff     <= (b_ff.op == ctbm_pkg::CMD_REMOVE);
         last_ff      <= b_ff.last;
         read_type_ff <= ((b_ff.op == ctbm_pkg::CMD_QUERY) && b_ff.hit)
                         ? 2'(stored_type) : 2'b00;
      end
   end

   assign rsp.valid      = rsp_vld_ff;
   assign rsp.cell_row   = row_ff;
   assign rsp.cell_col   = col_ff;
   assign rsp.cell_index = index_ff;
   assign rsp.blank      = blank_ff;
   assign rsp.read_type  = read_type_ff;
   assign rsp.last       = last_ff;

   // a clear empties the whole map at once
   assert property (@(posedge clock) disable iff (reset)
      (b_adv && b_clear) |=> (vld_ff == '0))
      else $error("map not empty after clear");

   // no read is issued while a clear is pending in execute
   assert property (@(posedge clock) disable iff (reset)
      (b_vld_ff && b_clear) |-> !pop)
      else $error("read issued under a clear");

   // the forward register tracks the latest write
   assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (fwd_vld_ff && (fwd_addr_ff == $past(b_ff.addr))))
      else $error("forward register lost the last write");

endmodule

`default_nettype wire

/* verif/ctbm_cell_checker.sv */
// response checker for the clipped tile block type map: tracks the packed type map
// and the clip box from accepted transactions and compares every response in order
// depends on ctbm_pkg and ctbm_intf
`timescale 1ns / 1ps

module ctbm_cell_checker (
   input  wire logic   clock,
   input  wire logic   reset,
   ctbm_req_if         req_bus,
   ctbm_rsp_if         rsp_bus,
   ctbm_csr_if         csr_bus,
   output int unsigned cells_pending,
   output int unsigned mismatch_count
);

   // one emitted cell as the response channel carries it
   typedef struct {
      logic [4:0] row;
      logic [4:0] col;
      logic [3:0] index;
      logic       blank;
      logic [1:0] read_type;
      logic       last;
   } emitted_cell_type;

   logic [7:0]       type_map [ctbm_pkg::MAP_BYTES];
   logic [4:0]       clip_top;
   logic [4:0]       clip_left;
   logic [4:0]       clip_height;
   logic [5:0]       clip_width;
   emitted_cell_type expected_cells [$];
   int unsigned      errors_seen = 0;

   // apply one command to the shadow map and queue the cells it emits
   task automatic predict_emitted_cells(input ctbm_pkg::cmd_type op, input logic [4:0] ar,
                                        input logic [4:0] ac, input logic [2:0] br_in,
                                        input logic [2:0] bc_in, input logic [1:0] draw_type);
      int               rows;
      int               cols;
      int               r;
      int               c;
      int               lin;
      int               shift;
      int               n;
      logic [1:0]       new_type;
      emitted_cell_type item;
      n = 0;
      case (op)
         ctbm_pkg::CMD_CLEAR: begin
            foreach (type_map[i]) type_map[i] = 8'h00;
         end
         ctbm_pkg::CMD_QUERY: begin
            item.row       = ar;
            item.col       = ac;
            item.index     = '0;
            item.blank     = 1'b0;
            item.last      = 1'b1;
            item.read_type = '0;
            // off-screen cells read as type zero
            if (ar < ctbm_pkg::SCREEN_ROWS && ac < ctbm_pkg::SCREEN_COLS) begin
               lin   = int'(ar) * ctbm_pkg::SCREEN_COLS + int'(ac);
               shift = (lin % ctbm_pkg::CELLS_PER_BYTE) * ctbm_pkg::TYPE_BITS;
               item.read_type = 2'((type_map[lin / ctbm_pkg::CELLS_PER_BYTE] >> shift)
                                   & ctbm_pkg::TYPE_MASK);
            end
            expected_cells.push_back(item);
         end
         default: begin
            // oversized blocks saturate, zero size walks nothing
            rows = (br_in > ctbm_pkg::MAX_BLOCK_ROWS) ? ctbm_pkg::MAX_BLOCK_ROWS
                                                      : int'(br_in);
            cols = (bc_in > ctbm_pkg::MAX_BLOCK_COLS) ? ctbm_pkg::MAX_BLOCK_COLS
                                                      : int'(bc_in);
            new_type = (op == ctbm_pkg::CMD_DRAW) ? draw_type : 2'b00;
            for (int dr = 0; dr < rows; dr++) begin
               for (int dc = 0; dc < cols; dc++) begin
                  r = int'(ar) + dr;
                  c = int'(ac) + dc;
                  if (r >= ctbm_pkg::SCREEN_ROWS || c >= ctbm_pkg::SCREEN_COLS) continue;
                  // only draws are clipped, no wrap below the box origin
                  if (op == ctbm_pkg::CMD_DRAW) begin
                     if (r < clip_top || r - clip_top >= clip_height) continue;
                     if (c < clip_left || c - clip_left >= clip_width) continue;
                  end
                  lin   = r * ctbm_pkg::SCREEN_COLS + c;
                  shift = (lin % ctbm_pkg::CELLS_PER_BYTE) * ctbm_pkg::TYPE_BITS;
                  type_map[lin / ctbm_pkg::CELLS_PER_BYTE] =
                     (type_map[lin / ctbm_pkg::CELLS_PER_BYTE]
                      & ~(ctbm_pkg::TYPE_MASK << shift))
                     | (8'(new_type) << shift);
                  item.row       = 5'(r);
                  item.col       = 5'(c);
                  item.index     = 4'(dr * cols + dc);
                  item.blank     = (op == ctbm_pkg::CMD_REMOVE);
                  item.read_type = '0;
                  item.last      = 1'b0;
                  expected_cells.push_back(item);
                  n++;
               end
            end
            if (n > 0) expected_cells[expected_cells.size() - 1].last = 1'b1;
         end
      endcase
   endtask

   // watch all three channels at each edge
   always @(posedge clock) begin : watch
      emitted_cell_type want;
      if (reset) begin
         foreach (type_map[i]) type_map[i] = 8'h00;
         clip_top    = 5'd0;
         clip_left   = 5'd0;
         clip_height = 5'd24;
         clip_width  = 6'd32;
         expected_cells.delete();
      end else begin
         // register writes
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               ctbm_pkg::CSR_CLIP_TOP:    clip_top    = csr_bus.data[4:0];
               ctbm_pkg::CSR_CLIP_LEFT:   clip_left   = csr_bus.data[4:0];
               ctbm_pkg::CSR_CLIP_HEIGHT: clip_height = csr_bus.data[4:0];
               ctbm_pkg::CSR_CLIP_WIDTH:  clip_width  = csr_bus.data[5:0];
               default: ;
            endcase
         end
         // command transactions
         if (req_bus.valid && req_bus.ready) begin
            predict_emitted_cells(ctbm_pkg::cmd_type'(req_bus.command), req_bus.anchor_row,
                                  req_bus.anchor_col, req_bus.block_rows,
                                  req_bus.block_cols, req_bus.cell_type);
         end
         // response transactions against the oldest expectation
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_cells.size() == 0) begin
               $error("unexpected response transaction: row %0d col %0d",
                      rsp_bus.cell_row, rsp_bus.cell_col);
               errors_seen++;
            end else begin
               want = expected_cells.pop_front();
               if (rsp_bus.cell_row !== want.row) begin
                  $error("cell_row: expected %0d, got %0d", want.row, rsp_bus.cell_row);
                  errors_seen++;
               end
               if (rsp_bus.cell_col !== want.col) begin
                  $error("cell_col: expected %0d, got %0d", want.col, rsp_bus.cell_col);
                  errors_seen++;
               end
               if (rsp_bus.cell_index !== want.index) begin
                  $error("cell_index: expected %0d, got %0d", want.index, rsp_bus.cell_index);
                  errors_seen++;
               end
               if (rsp_bus.blank !== want.blank) begin
                  $error("blank: expected %0d, got %0d", want.blank, rsp_bus.blank);
                  errors_seen++;
               end
               if (rsp_bus.read_type !== want.read_type) begin
                  $error("read_type: expected %0d, got %0d", want.read_type, rsp_bus.read_type);
                  errors_seen++;
               end
               if (rsp_bus.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_bus.last);
                  errors_seen++;
               end
            end
         end
      end
      cells_pending  <= expected_cells.size();
      mismatch_count <= errors_seen;
   end

endmodule

/* verif/tb_clipped_tile_block_type_map.sv */
// testbench top for the clipped tile block type map: clock, reset, command and
// register stimulus with random idling, final verdict
// depends on ctbm_pkg, ctbm_intf, the block and ctbm_cell_checker
`timescale 1ns / 1ps

module tb_clipped_tile_block_type_map;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int          SETTLE_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned cycle_count = 0;
   int unsigned cells_pending;
   int unsigned mismatch_count;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;

   ctbm_req_if req_bus ();
   ctbm_rsp_if rsp_bus ();
   ctbm_csr_if csr_bus ();

   clipped_tile_block_type_map u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   ctbm_cell_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_bus        (csr_bus),
      .cells_pending  (cells_pending),
      .mismatch_count (mismatch_count)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // response side: random stall before each transaction
   initial begin : rsp_drain
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // one command transaction after a random gap
   task automatic send_command(input ctbm_pkg::cmd_type op, input logic [4:0] row,
                               input logic [4:0] col, input logic [2:0] rows,
                               input logic [2:0] cols, input logic [1:0] draw_type);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= op;
      req_bus.anchor_row <= row;
      req_bus.anchor_col <= col;
      req_bus.block_rows <= rows;
      req_bus.block_cols <= cols;
      req_bus.cell_type  <= draw_type;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // wait until every expected cell is back, then let clears and empty walks finish
   task automatic drain_block();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (cells_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all four clip registers back to back while idle
   task automatic set_clip(input logic [5:0] top, input logic [5:0] left,
                           input logic [5:0] height, input logic [5:0] width);
      ctbm_pkg::csr_index_type               reg_order [4];
      logic [ctbm_pkg::CSR_DATA_W-1:0]       reg_value [4];
      reg_order = '{ctbm_pkg::CSR_CLIP_TOP, ctbm_pkg::CSR_CLIP_LEFT,
                    ctbm_pkg::CSR_CLIP_HEIGHT, ctbm_pkg::CSR_CLIP_WIDTH};
      reg_value = '{top, left, height, width};
      drain_block();
      for (int i = 0; i < 4; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= reg_order[i];
         csr_bus.data  <= reg_value[i];
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
   endtask

   // mostly on-screen, legal-size commands with some off-screen and odd sizes
   task automatic run_random(input int count);
      int                 pick;
      ctbm_pkg::cmd_type  op;
      logic [4:0]         row;
      logic [2:0]         rows;
      logic [2:0]         cols;
      for (int k = 0; k < count; k++) begin
         if (k % 25 == 0) begin
            req_calm = ($urandom_range(0, 3) == 0);
            rsp_calm = ($urandom_range(0, 3) == 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 45)      op = ctbm_pkg::CMD_DRAW;
         else if (pick < 65) op = ctbm_pkg::CMD_REMOVE;
         else if (pick < 97) op = ctbm_pkg::CMD_QUERY;
         else                op = ctbm_pkg::CMD_CLEAR;
         row  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, 23));
         rows = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(1, 4));
         cols = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(1, 4));
         send_command(op, row, 5'($urandom_range(0, 31)), rows, cols,
                      2'($urandom_range(0, 3)));
      end
   endtask

   initial begin : stimulus
      req_bus.valid      <= 1'b0;
      req_bus.command    <= ctbm_pkg::CMD_DRAW;
      req_bus.anchor_row <= '0;
      req_bus.anchor_col <= '0;
      req_bus.block_rows <= '0;
      req_bus.block_cols <= '0;
      req_bus.cell_type  <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= ctbm_pkg::CSR_CLIP_TOP;
      csr_bus.data       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full blocks, screen edges, saturation, zero sizes, clear
      send_command(ctbm_pkg::CMD_QUERY,  5'd0,  5'd0,  3'd1, 3'd1, 2'd0);
      send_command(ctbm_pkg::CMD_DRAW,   5'd0,  5'd0,  3'd4, 3'd4, 2'd3);
      send_command(ctbm_pkg::CMD_QUERY,  5'd0,  5'd0,  3'd0, 3'd0, 2'd0);
      send_command(ctbm_pkg::CMD_QUERY,  5'd3,  5'd3,  3'd7, 3'd7, 2'd3);
      send_command(ctbm_pkg::CMD_DRAW,   5'd22, 5'd30, 3'd4, 3'd4, 2'd2);
      send_command(ctbm_pkg::CMD_QUERY,  5'd23, 5'd31, 3'd1, 3'd1, 2'd0);
      send_command(ctbm_pkg::CMD_DRAW,   5'd31, 5'd31, 3'd7, 3'd7, 2'd1);
      send_command(ctbm_pkg::CMD_DRAW,   5'd10, 5'd10, 3'd0, 3'd4, 2'd2);
      send_command(ctbm_pkg::CMD_DRAW,   5'd10, 5'd10, 3'd7, 3'd6, 2'd1);
      send_command(ctbm_pkg::CMD_QUERY,  5'd13, 5'd13, 3'd1, 3'd1, 2'd0);
      send_command(ctbm_pkg::CMD_REMOVE, 5'd0,  5'd0,  3'd4, 3'd4, 2'd3);
      send_command(ctbm_pkg::CMD_REMOVE, 5'd21, 5'd29, 3'd7, 3'd7, 2'd2);
      send_command(ctbm_pkg::CMD_QUERY,  5'd23, 5'd31, 3'd1, 3'd1, 2'd0);
      send_command(ctbm_pkg::CMD_QUERY,  5'd31, 5'd31, 3'd1, 3'd1, 2'd0);
      send_command(ctbm_pkg::CMD_QUERY,  5'd24, 5'd0,  3'd1, 3'd1, 2'd0);
      send_command(ctbm_pkg::CMD_DRAW,   5'd5,  5'd5,  3'd2, 3'd3, 2'd0);
      send_command(ctbm_pkg::CMD_DRAW,   5'd23, 5'd0,  3'd1, 3'd1, 2'd3);
      send_command(ctbm_pkg::CMD_QUERY,  5'd23, 5'd0,  3'd1, 3'd1, 2'd0);
      send_command(ctbm_pkg::CMD_CLEAR,  5'd0,  5'd0,  3'd4, 3'd4, 2'd3);
      send_command(ctbm_pkg::CMD_QUERY,  5'd13, 5'd13, 3'd1, 3'd1, 2'd0);
      send_command(ctbm_pkg::CMD_REMOVE, 5'd8,  5'd8,  3'd3, 3'd0, 2'd0);
      send_command(ctbm_pkg::CMD_QUERY,  5'd31, 5'd0,  3'd1, 3'd1, 2'd0);

      // random phases over a range of clip boxes
      run_random(70);
      set_clip(6'd5, 6'd8, 6'd6, 6'd10);
      run_random(70);
      // single-cell box in the bottom right corner
      set_clip(6'd23, 6'd31, 6'd1, 6'd1);
      send_command(ctbm_pkg::CMD_DRAW, 5'd20, 5'd28, 3'd4, 3'd4, 2'd2);
      run_random(40);
      // empty boxes
      set_clip(6'd0, 6'd0, 6'd0, 6'd32);
      run_random(30);
      set_clip(6'd0, 6'd0, 6'd24, 6'd0);
      run_random(25);
      // origin past the screen, register data wider than the fields
      set_clip(6'd63, 6'd63, 6'd31, 6'd63);
      run_random(25);
      // box larger than the screen
      set_clip(6'd0, 6'd0, 6'd31, 6'd63);
      run_random(60);
      for (int p = 0; p < 3; p++) begin
         set_clip(6'($urandom_range(0, 23)), 6'($urandom_range(0, 31)),
                  6'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
         run_random(30);
      end
      set_clip(6'd0, 6'd0, 6'd24, 6'd32);
      run_random(40);

      drain_block();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* sim.f */
design/ctbm_pkg.sv
design/ctbm_intf.sv
design/ctbm_front.sv
design/ctbm_fifo.sv
design/ctbm_back.sv
design/clipped_tile_block_type_map.sv
verif/ctbm_cell_checker.sv
verif/tb_clipped_tile_block_type_map.sv
